/* hdl/cbba_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbba_pkg: shared types and constants of the colored bitmap block allocator
// Request and response beat layouts, configuration layout, and the codes for
// colors, request types, status values and register indexes.
// ----------------------------------------------------------------------------
package cbba_pkg;

  // Default number of heap blocks tracked by the color map.
  localparam int DEF_NUM_BLOCKS = 1024;

  // Width of the block count computed from a byte size (24 bits plus one).
  localparam int NEED_W = 25;

  // Block colors. Free is zero; the three run colors are tried in this order.
  localparam logic [1:0] COLOR_FREE  = 2'd0;
  localparam logic [1:0] COLOR_BLUE  = 2'd1;
  localparam logic [1:0] COLOR_RED   = 2'd2;
  localparam logic [1:0] COLOR_GREEN = 2'd3;

  // Request types.
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Response status codes.
  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_NO_RUN = 2'd1;
  localparam logic [1:0] STATUS_BAD    = 2'd2;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_SHIFT = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HEAP_BASE   = 1'd1;

  // Configuration register reset values.
  localparam logic [3:0]  BLOCK_SHIFT_RESET = 4'd6;
  localparam logic [31:0] HEAP_BASE_RESET   = 32'd0;

  typedef struct packed {
    logic        req_type;
    logic [23:0] request_bytes;
    logic [31:0] block_address;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] result_address;
    logic [1:0]  run_color;
  } rsp_t;

  typedef struct packed {
    logic [3:0]  block_shift;
    logic [31:0] heap_base;
  } cfg_t;

endpackage

/* hdl/cbba_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbba_engine: color map memory and the sequencer that walks it
// Holds the two-bit color of every heap block in a synchronous memory and
// runs the clearing pass, the first-fit allocate scan and the run release.
// ----------------------------------------------------------------------------
module cbba_engine #(
  parameter int NUM_BLOCKS = cbba_pkg::DEF_NUM_BLOCKS
) (
  input  logic           clk,
  input  logic           rst,
  input  cbba_pkg::cfg_t cfg,
  input  logic           start,
  input  cbba_pkg::req_t req,
  output logic           ready,
  output logic           done,
  output cbba_pkg::rsp_t res,
  input  logic           take
);
  import cbba_pkg::*;

  localparam int IDX_W = $clog2(NUM_BLOCKS);
  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(NUM_BLOCKS - 1);
  localparam logic [CNT_W-1:0] END_IDX  = CNT_W'(NUM_BLOCKS);

  typedef enum logic [3:0] {
    CLEAR, IDLE, A_SCAN, A_RIGHT, A_LEFT, A_FILL, F_IDX, F_CHK, F_FWD, F_BWD, FINISH
  } state_t;

  // Color map storage.
  logic [1:0]       mem [NUM_BLOCKS];
  logic [1:0]       rd_data;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [1:0]       wr_data;

  // Sequencer state. cur is the block whose color arrives on rd_data.
  state_t      state, state_next;
  logic [CNT_W-1:0] cur, cur_next;
  logic [CNT_W-1:0] run, run_next;
  logic [CNT_W-1:0] need, need_next;
  logic [IDX_W-1:0] first, first_next;
  logic [IDX_W-1:0] last, last_next;
  logic [IDX_W-1:0] fidx, fidx_next;
  logic [1:0]       color, color_next;
  logic [1:0]       right, right_next;
  logic [31:0]      offset, offset_next;
  rsp_t             res_next;

  function automatic logic [1:0] pick_color(input logic [1:0] lft, input logic [1:0] rgt);
    logic [1:0] c;
    if (lft != COLOR_BLUE && rgt != COLOR_BLUE) begin
      c = COLOR_BLUE;
    end else if (lft != COLOR_RED && rgt != COLOR_RED) begin
      c = COLOR_RED;
    end else begin
      c = COLOR_GREEN;
    end
    return c;
  endfunction

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  assign rd_addr = cur_next[IDX_W-1:0];
  assign ready   = (state == IDLE);
  assign done    = (state == FINISH);

  always_comb begin
    logic [NEED_W-1:0] need_w;
    logic [31:0]       idx_full;
    logic [CNT_W-1:0]  start_idx;
    logic [1:0]        lft;

    state_next  = state;
    cur_next    = cur;
    run_next    = run;
    need_next   = need;
    first_next  = first;
    last_next   = last;
    fidx_next   = fidx;
    color_next  = color;
    right_next  = right;
    offset_next = offset;
    res_next    = res;
    wr_en       = 1'b0;
    wr_addr     = cur[IDX_W-1:0];
    wr_data     = COLOR_FREE;

    need_w    = NEED_W'({1'b0, req.request_bytes} >> cfg.block_shift) + NEED_W'(1);
    idx_full  = offset >> cfg.block_shift;
    start_idx = cur + CNT_W'(1) - need;
    lft       = (first == '0) ? COLOR_FREE : rd_data;

    case (state)
      CLEAR: begin
        wr_en = 1'b1;
        if (cur == LAST_IDX) begin
          state_next = IDLE;
        end else begin
          cur_next = cur + CNT_W'(1);
        end
      end

      IDLE: begin
        if (start) begin
          res_next = '0;
          if (req.req_type == REQ_ALLOC) begin
            if (need_w >= NEED_W'(NUM_BLOCKS)) begin
              res_next.status = STATUS_BAD;
              state_next      = FINISH;
            end else begin
              need_next  = need_w[CNT_W-1:0];
              run_next   = '0;
              cur_next   = '0;
              state_next = A_SCAN;
            end
          end else begin
            offset_next = req.block_address - cfg.heap_base;
            state_next  = F_IDX;
          end
        end
      end

      // One block per cycle: the read of cur + 1 is already on its way.
      A_SCAN: begin
        cur_next = cur + CNT_W'(1);
        if (rd_data != COLOR_FREE) begin
          run_next = '0;
          if (cur == LAST_IDX) begin
            res_next.status = STATUS_NO_RUN;
            state_next      = FINISH;
          end
        end else if (run + CNT_W'(1) == need) begin
          last_next  = cur[IDX_W-1:0];
          first_next = start_idx[IDX_W-1:0];
          state_next = A_RIGHT;
        end else begin
          run_next = run + CNT_W'(1);
          if (cur == LAST_IDX) begin
            res_next.status = STATUS_NO_RUN;
            state_next      = FINISH;
          end
        end
      end

      // rd_data holds the block right after the run; then fetch the left one.
      A_RIGHT: begin
        right_next = (cur == END_IDX) ? COLOR_FREE : rd_data;
        cur_next   = CNT_W'(first) - CNT_W'(1);
        state_next = A_LEFT;
      end

      A_LEFT: begin
        color_next              = pick_color(lft, right);
        res_next.status         = STATUS_OK;
        res_next.run_color      = pick_color(lft, right);
        res_next.result_address = cfg.heap_base + (32'(first) << cfg.block_shift);
        cur_next                = CNT_W'(first);
        state_next              = A_FILL;
      end

      A_FILL: begin
        wr_en   = 1'b1;
        wr_data = color;
        if (cur[IDX_W-1:0] == last) begin
          state_next = FINISH;
        end else begin
          cur_next = cur + CNT_W'(1);
        end
      end

      F_IDX: begin
        if (idx_full >= 32'(NUM_BLOCKS)) begin
          res_next.status = STATUS_BAD;
          state_next      = FINISH;
        end else begin
          fidx_next  = idx_full[IDX_W-1:0];
          cur_next   = idx_full[CNT_W-1:0];
          state_next = F_CHK;
        end
      end

      F_CHK: begin
        if (rd_data == COLOR_FREE) begin
          res_next.status = STATUS_BAD;
          state_next      = FINISH;
        end else begin
          color_next = rd_data;
          wr_en      = 1'b1;
          if (cur != LAST_IDX) begin
            cur_next   = cur + CNT_W'(1);
            state_next = F_FWD;
          end else if (fidx == '0) begin
            state_next = FINISH;
          end else begin
            cur_next   = CNT_W'(fidx) - CNT_W'(1);
            state_next = F_BWD;
          end
        end
      end

      // Forward release while the color matches, at most up to the map end; then the backward walk from fidx.
      F_FWD: begin
        if (rd_data == color) begin
          wr_en = 1'b1;
        end
        if (rd_data == color && cur != LAST_IDX) begin
          cur_next = cur + CNT_W'(1);
        end else if (fidx == '0) begin
          state_next = FINISH;
        end else begin
          cur_next   = CNT_W'(fidx) - CNT_W'(1);
          state_next = F_BWD;
        end
      end

      F_BWD: begin
        if (rd_data == color) begin
          wr_en = 1'b1;
          if (cur == '0) begin
            state_next = FINISH;
          end else begin
            cur_next = cur - CNT_W'(1);
          end
        end else begin
          state_next = FINISH;
        end
      end

      FINISH: begin
        if (take) begin
          state_next = IDLE;
        end
      end

      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CLEAR;
      cur   <= '0;
    end else begin
      state <= state_next;
      cur   <= cur_next;
    end
    run    <= run_next;
    need   <= need_next;
    first  <= first_next;
    last   <= last_next;
    fidx   <= fidx_next;
    color  <= color_next;
    right  <= right_next;
    offset <= offset_next;
    res    <= res_next;
  end

endmodule

/* hdl/colored_bitmap_block_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// colored_bitmap_block_allocator: first-fit heap block allocator
// Tracks a two-bit color per heap block and serves allocate and free
// requests, one response beat per request beat.
// ----------------------------------------------------------------------------
// The heap is NUM_BLOCKS blocks of 2**block_shift bytes starting at heap_base.
// The block colors live in one single-port-read, single-port-write color map
// memory, walked one block per cycle, so timing follows that memory port.
// After reset the block clears the map and keeps req_stall high meanwhile;
// configuration writes are taken at any time.
// An allocate that succeeds scans the map up to the final block of the chosen
// run, reads the neighbor blocks on either side of the run, colors the run and
// hands the result over. An allocate that finds no room scans the whole map,
// and one that is too large answers without a scan. A free first checks that
// the address lies in the map and that its block is not free, then releases
// the run of that color forward to its end and backward to its start.
// Requests are handled one at a time, but a response beat waits in its own
// output register, so the next request beat is taken while the previous
// response is still stalled. A response that finds that register still full
// holds the sequencer until it drains.
module colored_bitmap_block_allocator #(
  parameter int NUM_BLOCKS = cbba_pkg::DEF_NUM_BLOCKS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 req_valid,
  output logic                                 req_stall,
  input  cbba_pkg::req_t                       req,
  output logic                                 rsp_valid,
  input  logic                                 rsp_stall,
  output cbba_pkg::rsp_t                       rsp,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [cbba_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [31:0]                          cfg_data
);
  import cbba_pkg::*;

  cfg_t cfg;
  logic eng_ready;
  logic eng_done;
  rsp_t eng_res;
  logic take;
  logic start;

  // The register file always accepts a write; writes are expected only while
  // no request is in flight.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.block_shift <= BLOCK_SHIFT_RESET;
      cfg.heap_base   <= HEAP_BASE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BLOCK_SHIFT: cfg.block_shift <= cfg_data[3:0];
        REG_HEAP_BASE:   cfg.heap_base   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // A request beat is taken whenever the sequencer is idle.
  assign req_stall = !eng_ready;
  assign start     = req_valid && !req_stall;

  // The finished result moves into the output register as soon as that
  // register is empty or being drained this cycle.
  assign take = eng_done && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
    if (take) begin
      rsp <= eng_res;
    end
  end

  cbba_engine #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) u_engine (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .start(start),
    .req  (req),
    .ready(eng_ready),
    .done (eng_done),
    .res  (eng_res),
    .take (take)
  );

endmodule
